/* design/madt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MADT parser package
// Shared constants, record codes and state structures of the interrupt
// controller table parser.
// ----------------------------------------------------------------------------
package madt_pkg;

	localparam int MAX_CPUS_DEF = 64;
	localparam int CNT_W        = 9;
	localparam int ISA_IRQS     = 16;
	localparam int BUF_LEN      = 12;

	localparam logic [5:0] HDR_LEN  = 6'd44;
	localparam logic [5:0] LEN_OFF  = 6'd4;
	localparam logic [5:0] BASE_OFF = 6'd36;

	localparam logic [31:0] DEFAULT_LOCAL_BASE = 32'hFEE0_0000;

	localparam logic [7:0] REC_LOCAL_CTRL  = 8'd0;
	localparam logic [7:0] REC_IO_CTRL     = 8'd1;
	localparam logic [7:0] REC_SRC_OVR     = 8'd2;
	localparam logic [7:0] REC_LOCAL_ADDR  = 8'd5;

	localparam logic [7:0] MIN_LEN_LOCAL_CTRL = 8'd8;
	localparam logic [7:0] MIN_LEN_IO_CTRL    = 8'd12;
	localparam logic [7:0] MIN_LEN_SRC_OVR    = 8'd10;
	localparam logic [7:0] MIN_LEN_LOCAL_ADDR = 8'd12;

	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef logic [ISA_IRQS-1:0][31:0] gsi_map_t;
	typedef logic [ISA_IRQS-1:0][15:0] flag_map_t;

	typedef struct packed {
		logic [CNT_W-1:0] cpu_count;
		logic [31:0]      local_base;
		logic [31:0]      io_base;
		logic [31:0]      io_gsi_base;
		gsi_map_t         gsi_map;
		flag_map_t        flag_map;
	} parse_state_t;

	typedef struct packed {
		logic       en;
		logic [7:0] slot;
		logic [7:0] apic_id;
	} cpu_wr_t;

endpackage

/* design/madt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module madt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/madt_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MADT byte parser
// Walks the table header and records one byte per cycle and keeps the
// parsed controller bases, ISA interrupt map and CPU count.
// ----------------------------------------------------------------------------
module madt_parser #(
	parameter int MAX_CPUS = madt_pkg::MAX_CPUS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_en,
	input  logic                  first,
	input  logic [7:0]            data_byte,
	output madt_pkg::parse_state_t state,
	output madt_pkg::cpu_wr_t     cpu_wr
);

	logic                             stopped_q, stopped_d;
	logic [5:0]                       hdr_q, hdr_d;
	logic [31:0]                      tlen_q, tlen_d;
	logic [31:0]                      rem_q, rem_d;
	logic [7:0]                       off_q, off_d;
	logic [madt_pkg::BUF_LEN-1:0][7:0] buf_q, buf_d;
	logic [madt_pkg::CNT_W-1:0]       cnt_q, cnt_d;
	logic [31:0]                      local_q, local_d;
	logic [31:0]                      io_q, io_d;
	logic [31:0]                      gsib_q, gsib_d;
	madt_pkg::gsi_map_t               gsi_q, gsi_d;
	madt_pkg::flag_map_t              flag_q, flag_d;

	logic       act;
	logic [5:0] hdr_c;
	logic [7:0] len;
	logic [7:0] src;

	always_comb begin
		stopped_d = stopped_q;
		hdr_d     = hdr_q;
		tlen_d    = tlen_q;
		rem_d     = rem_q;
		off_d     = off_q;
		buf_d     = buf_q;
		cnt_d     = cnt_q;
		local_d   = local_q;
		io_d      = io_q;
		gsib_d    = gsib_q;
		gsi_d     = gsi_q;
		flag_d    = flag_q;
		cpu_wr    = '0;
		len       = buf_q[1];
		src       = buf_q[3];
		act       = byte_en && (first || !stopped_q);
		hdr_c     = first ? 6'd0 : hdr_q;

		if (byte_en && first) begin
			stopped_d = 1'b0;
			tlen_d    = '0;
			hdr_d     = '0;
		end

		if (act) begin
			if (hdr_c != madt_pkg::HDR_LEN) begin
				if (hdr_c >= madt_pkg::LEN_OFF && hdr_c < madt_pkg::LEN_OFF + 6'd4) begin
					tlen_d[8*hdr_c[1:0] +: 8] = data_byte;
				end else if (hdr_c >= madt_pkg::BASE_OFF &&
					hdr_c < madt_pkg::BASE_OFF + 6'd4) begin
					buf_d[hdr_c[1:0]] = data_byte;
				end
				if (hdr_c == madt_pkg::HDR_LEN - 6'd1) begin
					if (tlen_d < 32'(madt_pkg::HDR_LEN)) begin
						stopped_d = 1'b1;
					end else begin
						local_d = {buf_d[3], buf_d[2], buf_d[1], buf_d[0]};
						for (int i = 0; i < madt_pkg::ISA_IRQS; i++) begin
							gsi_d[i]  = 32'(i);
							flag_d[i] = '0;
						end
						rem_d = tlen_d - 32'(madt_pkg::HDR_LEN);
						off_d = '0;
						hdr_d = madt_pkg::HDR_LEN;
					end
				end else begin
					hdr_d = hdr_c + 6'd1;
				end
			end else if (rem_q == '0) begin
				stopped_d = 1'b1;
			end else begin
				if (off_q < 8'(madt_pkg::BUF_LEN)) begin
					buf_d[off_q[3:0]] = data_byte;
				end
				len = buf_d[1];
				src = buf_d[3];
				rem_d = rem_q - 32'd1;
				if (off_q == 8'd0) begin
					off_d = 8'd1;
					if (rem_q == 32'd1) begin
						stopped_d = 1'b1;
					end
				end else if (off_q == 8'd1 &&
					(len < 8'd2 || 33'(len) > 33'(rem_q) + 33'd1)) begin
					stopped_d = 1'b1;
				end else if (off_q + 8'd1 == len) begin
					off_d = '0;
					if (rem_q == 32'd1) begin
						stopped_d = 1'b1;
					end
					if (buf_d[0] == madt_pkg::REC_LOCAL_CTRL &&
						len >= madt_pkg::MIN_LEN_LOCAL_CTRL) begin
						if (buf_d[4][0] && cnt_q < madt_pkg::CNT_W'(MAX_CPUS)) begin
							cpu_wr.en      = 1'b1;
							cpu_wr.slot    = cnt_q[7:0];
							cpu_wr.apic_id = buf_d[3];
							cnt_d          = cnt_q + 1'b1;
						end
					end else if (buf_d[0] == madt_pkg::REC_IO_CTRL &&
						len >= madt_pkg::MIN_LEN_IO_CTRL) begin
						if (io_q == '0) begin
							io_d   = {buf_d[7], buf_d[6], buf_d[5], buf_d[4]};
							gsib_d = {buf_d[11], buf_d[10], buf_d[9], buf_d[8]};
						end
					end else if (buf_d[0] == madt_pkg::REC_SRC_OVR &&
						len >= madt_pkg::MIN_LEN_SRC_OVR) begin
						if (src < 8'(madt_pkg::ISA_IRQS)) begin
							gsi_d[src[3:0]]  = {buf_d[7], buf_d[6], buf_d[5], buf_d[4]};
							flag_d[src[3:0]] = {buf_d[9], buf_d[8]};
						end
					end else if (buf_d[0] == madt_pkg::REC_LOCAL_ADDR &&
						len >= madt_pkg::MIN_LEN_LOCAL_ADDR) begin
						if ({buf_d[11], buf_d[10], buf_d[9], buf_d[8]} == '0) begin
							local_d = {buf_d[7], buf_d[6], buf_d[5], buf_d[4]};
						end
					end
				end else begin
					off_d = off_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b1;
			hdr_q     <= '0;
			tlen_q    <= '0;
			rem_q     <= '0;
			off_q     <= '0;
			cnt_q     <= '0;
			local_q   <= madt_pkg::DEFAULT_LOCAL_BASE;
			io_q      <= '0;
			gsib_q    <= '0;
			gsi_q     <= '0;
			flag_q    <= '0;
		end else begin
			stopped_q <= stopped_d;
			hdr_q     <= hdr_d;
			tlen_q    <= tlen_d;
			rem_q     <= rem_d;
			off_q     <= off_d;
			cnt_q     <= cnt_d;
			local_q   <= local_d;
			io_q      <= io_d;
			gsib_q    <= gsib_d;
			gsi_q     <= gsi_d;
			flag_q    <= flag_d;
		end
	end

	always_ff @(posedge clk) begin
		buf_q <= buf_d;
	end

	assign state.cpu_count   = cnt_q;
	assign state.local_base  = local_q;
	assign state.io_base     = io_q;
	assign state.io_gsi_base = gsib_q;
	assign state.gsi_map     = gsi_q;
	assign state.flag_map    = flag_q;

endmodule

/* design/madt_query.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MADT query result stage
// Forms the answer to a query from the parsed state and holds it in the
// output register until the transfer completes.
// ----------------------------------------------------------------------------
module madt_query (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [7:0]             query_index,
	input  logic [7:0]             slot_id,
	input  madt_pkg::parse_state_t state,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             cpu_apic_id,
	output logic [31:0]            irq_gsi,
	output logic [15:0]            irq_polarity_flags,
	output logic [8:0]             cpu_total,
	output logic [31:0]            local_ctrl_base,
	output logic [31:0]            io_ctrl_base,
	output logic [31:0]            io_ctrl_gsi_base
);

	logic isa_irq;

	assign isa_irq = query_index < 8'(madt_pkg::ISA_IRQS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cpu_apic_id <= ({1'b0, query_index} < state.cpu_count) ? slot_id : 8'd0;
			irq_gsi <= isa_irq ? state.gsi_map[query_index[3:0]] : 32'(query_index);
			irq_polarity_flags <= isa_irq ? state.flag_map[query_index[3:0]] : 16'd0;
			cpu_total        <= state.cpu_count;
			local_ctrl_base  <= state.local_base;
			io_ctrl_base     <= state.io_base;
			io_ctrl_gsi_base <= state.io_gsi_base;
		end
	end

endmodule

/* design/madt_record_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MADT record parser unit
// Streams an interrupt controller description table byte by byte and
// answers queries about the CPUs, controller bases and ISA IRQ routing.
// ----------------------------------------------------------------------------
// A query passes from the input register to the output register, from which it transfers out.
// Throughput: one item per cycle unless a query waits on a full output register; table bytes produce no result.
// The input register advances unless a query waits on a full output register.
// Reset clears all control state; the parser starts stopped until a first byte.
// The CPU id RAM has no reset; only written slots are ever returned.
module madt_record_parser_unit #(
	parameter int MAX_CPUS = madt_pkg::MAX_CPUS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic        first,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  query_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  cpu_apic_id,
	output logic [31:0] irq_gsi,
	output logic [15:0] irq_polarity_flags,
	output logic [8:0]  cpu_total,
	output logic [31:0] local_ctrl_base,
	output logic [31:0] io_ctrl_base,
	output logic [31:0] io_ctrl_gsi_base
);

	localparam int AW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

	logic       valid_s1;
	logic       kind_s1;
	logic       first_s1;
	logic [7:0] data_s1;
	logic [7:0] qidx_s1;
	logic       byp_s1;
	logic [7:0] byp_id_s1;
	logic       go_s1;
	logic       accept;
	logic [7:0] ram_rdata;

	madt_pkg::parse_state_t state;
	madt_pkg::cpu_wr_t      cpu_wr;

	assign go_s1 = valid_s1 && (kind_s1 == madt_pkg::KIND_BYTE || !out_valid || out_ready);
	assign in_ready = !valid_s1 || go_s1;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			first_s1  <= first;
			data_s1   <= data_byte;
			qidx_s1   <= query_index;
			byp_s1    <= cpu_wr.en && cpu_wr.slot == query_index;
			byp_id_s1 <= cpu_wr.apic_id;
		end
	end

	madt_ram #(
		.WIDTH(8),
		.DEPTH(MAX_CPUS)
	) u_cpu_ram (
		.clk  (clk),
		.we   (cpu_wr.en),
		.waddr(cpu_wr.slot[AW-1:0]),
		.wdata(cpu_wr.apic_id),
		.re   (accept),
		.raddr(query_index[AW-1:0]),
		.rdata(ram_rdata)
	);

	madt_parser #(
		.MAX_CPUS(MAX_CPUS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_en  (go_s1 && kind_s1 == madt_pkg::KIND_BYTE),
		.first    (first_s1),
		.data_byte(data_s1),
		.state    (state),
		.cpu_wr   (cpu_wr)
	);

	madt_query u_query (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (go_s1 && kind_s1 == madt_pkg::KIND_QUERY),
		.query_index       (qidx_s1),
		.slot_id           (byp_s1 ? byp_id_s1 : ram_rdata),
		.state             (state),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.cpu_apic_id       (cpu_apic_id),
		.irq_gsi           (irq_gsi),
		.irq_polarity_flags(irq_polarity_flags),
		.cpu_total         (cpu_total),
		.local_ctrl_base   (local_ctrl_base),
		.io_ctrl_base      (io_ctrl_base),
		.io_ctrl_gsi_base  (io_ctrl_gsi_base)
	);

endmodule

/* tb/madt_record_parser_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MADT record parser unit testbench
// Streams randomized interrupt controller tables, some well formed and some
// broken on purpose, with queries mixed in. A behavioral copy of the parser
// predicts every query answer, and a monitor compares each answer field by
// field. Both sides idle at random, and the receiver once holds off long
// enough to stall the input.
// ----------------------------------------------------------------------------
module madt_record_parser_unit_test;
	import madt_pkg::*;

	localparam int ITEM_GOAL     = 950;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 8;
	localparam int SHAPE_COUNT   = 9;

	typedef enum int {
		TBL_IO_REOPEN,
		TBL_CLEAN,
		TBL_SHORT_HDR,
		TBL_TAIL_BYTE,
		TBL_BAD_REC_LEN,
		TBL_OVERRUN,
		TBL_TRAILING,
		TBL_CUT_SHORT,
		TBL_HUGE_LEN
	} table_shape_e;

	typedef struct packed {
		logic       kind;
		logic       first;
		logic [7:0] data_byte;
		logic [7:0] query_index;
	} madt_item_t;

	typedef struct packed {
		logic [7:0]  cpu_apic_id;
		logic [31:0] irq_gsi;
		logic [15:0] irq_polarity_flags;
		logic [8:0]  cpu_total;
		logic [31:0] local_ctrl_base;
		logic [31:0] io_ctrl_base;
		logic [31:0] io_ctrl_gsi_base;
	} madt_answer_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic        kind        = KIND_BYTE;
	logic        first       = 1'b0;
	logic [7:0]  data_byte   = 8'd0;
	logic [7:0]  query_index = 8'd0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [7:0]  cpu_apic_id;
	logic [31:0] irq_gsi;
	logic [15:0] irq_polarity_flags;
	logic [8:0]  cpu_total;
	logic [31:0] local_ctrl_base;
	logic [31:0] io_ctrl_base;
	logic [31:0] io_ctrl_gsi_base;

	madt_record_parser_unit dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.kind               (kind),
		.first              (first),
		.data_byte          (data_byte),
		.query_index        (query_index),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.cpu_apic_id        (cpu_apic_id),
		.irq_gsi            (irq_gsi),
		.irq_polarity_flags (irq_polarity_flags),
		.cpu_total          (cpu_total),
		.local_ctrl_base    (local_ctrl_base),
		.io_ctrl_base       (io_ctrl_base),
		.io_ctrl_gsi_base   (io_ctrl_gsi_base)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	madt_item_t   stimulus[$];
	madt_answer_t expected_answers[$];
	logic [7:0]   tbl_bytes[$];
	madt_item_t   next_item;
	madt_answer_t want;
	int           accepted_items = 0;
	int           total_items    = 0;
	int           error_count    = 0;
	int           hold_start     = 0;
	int           hold_left      = 0;
	bit           hold_used      = 1'b0;

	// Parser state as the block should hold it.
	logic [31:0] pos_q;
	logic [31:0] length_q;
	logic [31:0] rec_start_q;
	logic [7:0]  rec_buf [BUF_LEN];
	logic        stopped_q;
	logic [7:0]  cpu_ids [MAX_CPUS_DEF];
	logic [8:0]  cpu_cnt;
	logic [31:0] local_base_q;
	logic [31:0] io_base_q;
	logic [31:0] io_gsi_base_q;
	logic [31:0] gsi_map [ISA_IRQS];
	logic [15:0] flag_map [ISA_IRQS];

	task automatic clear_parser_state();
		pos_q         = 32'd0;
		length_q      = 32'd0;
		rec_start_q   = 32'd0;
		stopped_q     = 1'b1;
		cpu_cnt       = 9'd0;
		local_base_q  = DEFAULT_LOCAL_BASE;
		io_base_q     = 32'd0;
		io_gsi_base_q = 32'd0;
		for (int i = 0; i < BUF_LEN; i++)
			rec_buf[i] = 8'd0;
		for (int i = 0; i < ISA_IRQS; i++) begin
			gsi_map[i]  = 32'd0;
			flag_map[i] = 16'd0;
		end
	endtask

	function automatic logic [31:0] buf_word(int at);
		return {rec_buf[at + 3], rec_buf[at + 2], rec_buf[at + 1], rec_buf[at]};
	endfunction

	task automatic apply_record();
		logic [7:0] rtype;
		logic [7:0] rlen;
		logic [7:0] src;
		rtype = rec_buf[0];
		rlen  = rec_buf[1];
		src   = rec_buf[3];
		if (rtype == REC_LOCAL_CTRL && rlen >= MIN_LEN_LOCAL_CTRL) begin
			if (rec_buf[4][0] && cpu_cnt < MAX_CPUS_DEF) begin
				cpu_ids[cpu_cnt] = rec_buf[3];
				cpu_cnt++;
			end
		end else if (rtype == REC_IO_CTRL && rlen >= MIN_LEN_IO_CTRL) begin
			if (io_base_q == 32'd0) begin
				io_base_q     = buf_word(4);
				io_gsi_base_q = buf_word(8);
			end
		end else if (rtype == REC_SRC_OVR && rlen >= MIN_LEN_SRC_OVR) begin
			if (src < ISA_IRQS) begin
				gsi_map[src[3:0]]  = buf_word(4);
				flag_map[src[3:0]] = {rec_buf[9], rec_buf[8]};
			end
		end else if (rtype == REC_LOCAL_ADDR && rlen >= MIN_LEN_LOCAL_ADDR) begin
			if (buf_word(8) == 32'd0)
				local_base_q = buf_word(4);
		end
	endtask

	task automatic absorb_table_byte(logic start, logic [7:0] b);
		logic [31:0] off;
		logic [7:0]  rlen;
		if (start) begin
			pos_q       = 32'd0;
			length_q    = 32'd0;
			rec_start_q = 32'd0;
			stopped_q   = 1'b0;
			for (int i = 0; i < BUF_LEN; i++)
				rec_buf[i] = 8'd0;
		end
		if (!stopped_q) begin
			if (pos_q < HDR_LEN) begin
				if (pos_q >= LEN_OFF && pos_q < LEN_OFF + 4)
					length_q |= 32'(b) << (8 * (pos_q - LEN_OFF));
				else if (pos_q >= BASE_OFF && pos_q < BASE_OFF + 4)
					rec_buf[pos_q - BASE_OFF] = b;
				if (pos_q == HDR_LEN - 1) begin
					if (length_q < HDR_LEN) begin
						stopped_q = 1'b1;
					end else begin
						local_base_q = buf_word(0);
						for (int i = 0; i < ISA_IRQS; i++) begin
							gsi_map[i]  = 32'(i);
							flag_map[i] = 16'd0;
						end
						rec_start_q = 32'(HDR_LEN);
					end
				end
			end else if (pos_q >= length_q || pos_q < rec_start_q) begin
				stopped_q = 1'b1;
			end else begin
				off = pos_q - rec_start_q;
				if (off < BUF_LEN)
					rec_buf[off] = b;
				rlen = rec_buf[1];
				if (off == 0) begin
					if ({1'b0, rec_start_q} + 33'd2 > {1'b0, length_q})
						stopped_q = 1'b1;
				end else if (off == 1 && (rlen < 2 ||
						{1'b0, rec_start_q} + 33'(rlen) > {1'b0, length_q})) begin
					stopped_q = 1'b1;
				end else if (off + 1 == 32'(rlen)) begin
					apply_record();
					rec_start_q += 32'(rlen);
					if (rec_start_q >= length_q)
						stopped_q = 1'b1;
				end
			end
			if (pos_q != 32'hFFFF_FFFF)
				pos_q++;
		end
	endtask

	function automatic madt_answer_t answer_query(logic [7:0] q);
		madt_answer_t a;
		a.cpu_apic_id        = (q < cpu_cnt) ? cpu_ids[q] : 8'd0;
		a.irq_gsi            = (q < ISA_IRQS) ? gsi_map[q[3:0]] : 32'(q);
		a.irq_polarity_flags = (q < ISA_IRQS) ? flag_map[q[3:0]] : 16'd0;
		a.cpu_total          = cpu_cnt;
		a.local_ctrl_base    = local_base_q;
		a.io_ctrl_base       = io_base_q;
		a.io_ctrl_gsi_base   = io_gsi_base_q;
		return a;
	endfunction

	task automatic push_query(int idx);
		madt_item_t it;
		it.kind      = KIND_QUERY;
		it.first     = 1'($urandom_range(1));
		it.data_byte = 8'($urandom);
		if (idx >= 0)
			it.query_index = 8'(idx);
		else
			case ($urandom_range(3))
				0, 1: it.query_index = 8'($urandom_range(17));
				2: it.query_index = 8'($urandom_range(80));
				default: it.query_index = 8'($urandom);
			endcase
		stimulus.push_back(it);
	endtask

	task automatic push_byte(logic start, logic [7:0] b);
		madt_item_t it;
		it.kind        = KIND_BYTE;
		it.first       = start;
		it.data_byte   = b;
		it.query_index = 8'($urandom);
		stimulus.push_back(it);
		if ($urandom_range(99) < 12)
			push_query(-1);
	endtask

	task automatic append_record(int want_type, bit zero_io);
		logic [7:0] rec [256];
		logic [7:0] rtype;
		logic [7:0] rlen;
		logic [7:0] min_len;
		int         pick;
		pick = $urandom_range(99);
		if (want_type >= 0)
			rtype = 8'(want_type);
		else if (pick < 62)
			rtype = REC_LOCAL_CTRL;
		else if (pick < 72)
			rtype = REC_IO_CTRL;
		else if (pick < 86)
			rtype = REC_SRC_OVR;
		else if (pick < 92)
			rtype = REC_LOCAL_ADDR;
		else begin
			rtype = 8'($urandom_range(3, 255));
			if (rtype == REC_LOCAL_ADDR)
				rtype = 8'd4;
		end
		case (rtype)
			REC_LOCAL_CTRL: min_len = MIN_LEN_LOCAL_CTRL;
			REC_IO_CTRL:    min_len = MIN_LEN_IO_CTRL;
			REC_SRC_OVR:    min_len = MIN_LEN_SRC_OVR;
			REC_LOCAL_ADDR: min_len = MIN_LEN_LOCAL_ADDR;
			default:        min_len = 8'd2;
		endcase
		if (want_type >= 0)
			rlen = min_len;
		else if (min_len == 8'd2)
			rlen = 8'($urandom_range(2, 24));
		else
			case ($urandom_range(9))
				0: rlen = 8'($urandom_range(2, min_len - 1));
				1, 2: rlen = 8'($urandom_range(min_len, min_len + 30));
				default: rlen = min_len;
			endcase
		for (int i = 0; i < 256; i++)
			rec[i] = 8'($urandom);
		rec[0] = rtype;
		rec[1] = rlen;
		case (rtype)
			REC_LOCAL_CTRL: begin
				rec[4][0] = ($urandom_range(99) < 85);
			end
			REC_IO_CTRL: begin
				if (zero_io || (want_type < 0 && $urandom_range(3) == 0))
					for (int i = 4; i < 8; i++)
						rec[i] = 8'd0;
			end
			REC_SRC_OVR: begin
				if ($urandom_range(9) < 7)
					rec[3] = 8'($urandom_range(15));
			end
			REC_LOCAL_ADDR: begin
				if ($urandom_range(9) < 7)
					for (int i = 8; i < 12; i++)
						rec[i] = 8'd0;
			end
			default: ;
		endcase
		for (int i = 0; i < rlen; i++)
			tbl_bytes.push_back(rec[i]);
	endtask

	task automatic emit_table(table_shape_e shape);
		logic [31:0] len_field;
		logic [31:0] base;
		int          cut;
		tbl_bytes.delete();
		for (int i = 0; i < HDR_LEN; i++)
			tbl_bytes.push_back(8'($urandom));
		base = ($urandom_range(3) == 0) ? DEFAULT_LOCAL_BASE : 32'($urandom);
		for (int i = 0; i < 4; i++)
			tbl_bytes[BASE_OFF + i] = base[8 * i +: 8];
		if (shape == TBL_IO_REOPEN) begin
			append_record(REC_IO_CTRL, 1'b1);
			append_record(REC_IO_CTRL, 1'b0);
			append_record(REC_LOCAL_CTRL, 1'b0);
			append_record(REC_SRC_OVR, 1'b0);
			append_record(REC_LOCAL_ADDR, 1'b0);
		end
		repeat ($urandom_range(3, 12))
			append_record(-1, 1'b0);
		case (shape)
			TBL_SHORT_HDR: len_field = $urandom_range(0, HDR_LEN - 1);
			TBL_TAIL_BYTE: begin
				tbl_bytes.push_back(8'($urandom));
				len_field = tbl_bytes.size();
			end
			TBL_BAD_REC_LEN: begin
				tbl_bytes.push_back(8'($urandom));
				tbl_bytes.push_back(8'($urandom_range(1)));
				repeat (6)
					tbl_bytes.push_back(8'($urandom));
				len_field = tbl_bytes.size();
			end
			TBL_OVERRUN: begin
				tbl_bytes.push_back(8'($urandom));
				tbl_bytes.push_back(8'($urandom_range(11, 255)));
				repeat (8)
					tbl_bytes.push_back(8'($urandom));
				len_field = tbl_bytes.size();
			end
			TBL_TRAILING: begin
				len_field = tbl_bytes.size();
				repeat ($urandom_range(1, 20))
					tbl_bytes.push_back(8'($urandom));
			end
			TBL_HUGE_LEN: len_field = $urandom | 32'h0100_0000;
			default: len_field = tbl_bytes.size();
		endcase
		for (int i = 0; i < 4; i++)
			tbl_bytes[LEN_OFF + i] = len_field[8 * i +: 8];
		if (shape == TBL_CUT_SHORT) begin
			cut = $urandom_range(1, tbl_bytes.size() - 1);
			while (tbl_bytes.size() > cut)
				void'(tbl_bytes.pop_back());
		end
		foreach (tbl_bytes[i])
			push_byte(i == 0, tbl_bytes[i]);
	endtask

	function automatic int idle_pct(bit receiver);
		if (accepted_items < total_items / 3)
			return receiver ? 63 : 28;
		else if (accepted_items < 2 * total_items / 3)
			return receiver ? 28 : 63;
		else
			return 0;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (act_val !== exp_val) begin
			error_count++;
			$display("%0t: %s expected %0h, actual %0h", $time, name, exp_val, act_val);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (kind == KIND_QUERY)
					expected_answers.push_back(answer_query(query_index));
				else
					absorb_table_byte(first, data_byte);
				accepted_items++;
			end
			if (!in_valid || in_ready) begin
				if (stimulus.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
					next_item = stimulus.pop_front();
					in_valid    <= 1'b1;
					kind        <= next_item.kind;
					first       <= next_item.first;
					data_byte   <= next_item.data_byte;
					query_index <= next_item.query_index;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_used && accepted_items >= hold_start) begin
				hold_used <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_pct(1'b1));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_answers.size() == 0) begin
				error_count++;
				$display("%0t: result with no query pending, actual cpu_total %0d irq_gsi %0h",
					$time, cpu_total, irq_gsi);
			end else begin
				want = expected_answers.pop_front();
				check_field("cpu_apic_id", 32'(want.cpu_apic_id), 32'(cpu_apic_id));
				check_field("irq_gsi", want.irq_gsi, irq_gsi);
				check_field("irq_polarity_flags", 32'(want.irq_polarity_flags),
					32'(irq_polarity_flags));
				check_field("cpu_total", 32'(want.cpu_total), 32'(cpu_total));
				check_field("local_ctrl_base", want.local_ctrl_base, local_ctrl_base);
				check_field("io_ctrl_base", want.io_ctrl_base, io_ctrl_base);
				check_field("io_ctrl_gsi_base", want.io_ctrl_gsi_base, io_ctrl_gsi_base);
			end
		end
	end

	initial begin
		int cycles;
		int limit;
		clear_parser_state();
		cycles = 0;

		push_query(0);
		push_query(ISA_IRQS - 1);
		push_query(ISA_IRQS);
		push_query(255);
		push_byte(1'b0, 8'hFF);
		push_byte(1'b0, 8'h00);
		for (int t = 0; stimulus.size() < ITEM_GOAL; t++) begin
			if (t < SHAPE_COUNT)
				emit_table(table_shape_e'(t));
			else if ($urandom_range(99) < 50)
				emit_table(TBL_CLEAN);
			else
				emit_table(table_shape_e'($urandom_range(SHAPE_COUNT - 1)));
		end
		for (int i = 0; i <= ISA_IRQS; i++)
			push_query(i);
		push_query(MAX_CPUS_DEF - 1);
		push_query(MAX_CPUS_DEF);

		total_items = stimulus.size();
		hold_start  = total_items * 5 / 6;
		limit       = 60 * total_items + 20000;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while ((accepted_items < total_items || expected_answers.size() != 0) &&
				cycles < limit) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= limit) begin
			error_count++;
			$display("%0t: run timed out with %0d answers outstanding",
				$time, expected_answers.size());
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
